// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key/value cache
// Command and status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned CAP_BITS       = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_FIND   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_NULL = 2'd2,
    STAT_MISS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESP
  } fsm_e;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key/value cache, LRU order
// Steps: a null insert goes straight to the result; a duplicate, a miss or an insert
//   dropped at zero capacity takes one scan pass over all entries; a stored insert or
//   a hit takes a scan pass and then a rank update pass. One request at a time: the
//   input is stalled until the result of the busy request has been registered.
// The single key comparator serves the scan pass and the single rank RAM port
//   both passes, once per entry each. Reset: valid bits and count cleared, capacity 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [KEY_BITS-1:0]           lookup_key_i,
  input  logic [VALUE_BITS-1:0]         entry_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [VALUE_BITS-1:0]         found_value_o
);

  import lkvc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;

  fsm_e                  state_q, state_d;
  logic [CAP_BITS-1:0]   cap_q, cap_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  cmd_e                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]      hit_rank_q, hit_rank_d;
  logic [VALUE_BITS-1:0] hit_val_q, hit_val_d;
  logic [IDX_W-1:0]      vict_idx_q, vict_idx_d;
  logic                  free_q, free_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  status_e               res_status_q, res_status_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;

  logic                  in_acc;
  logic                  null_ins;
  logic                  cnt_end;
  logic                  out_free;
  logic                  pend_valid;
  logic [CMP_W-1:0]      cap_eff;
  logic                  over;
  logic                  go_update;
  logic [IDX_W-1:0]      slot_sel;
  logic [IDX_W-1:0]      raddr;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [IDX_W-1:0]      rank_rd;
  logic                  kv_we;
  logic                  rank_we;
  logic [IDX_W-1:0]      rank_wdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign null_ins   = (command_i == CMD_INSERT) && (entry_value_i == '0);
  assign cnt_end    = (cnt_q == CNT_W'(ENTRIES));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pend_valid = valid_q[pend_idx_q];
  assign raddr      = cnt_q[IDX_W-1:0];

  // capacity clamped to storage size
  assign cap_eff = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
  assign over    = (CMP_W'(count_q) + CMP_W'(1)) > cap_eff;

  always_comb begin
    if (cmd_q == CMD_INSERT) begin
      go_update = !hit_q && !(over && (count_q == '0));
    end else begin
      go_update = hit_q;
    end
  end

  // first free slot once the victim is gone
  assign slot_sel = (over && (!free_q || (vict_idx_q < free_idx_q))) ? vict_idx_q : free_idx_q;

  assign kv_we   = (state_q == ST_DECIDE) && (cmd_q == CMD_INSERT) && go_update;
  assign rank_we = (state_q == ST_UPDATE) && pend_q && pend_valid;

  always_comb begin
    if (pend_idx_q == slot_q) begin
      rank_wdata = '0;
    end else if ((cmd_q == CMD_INSERT) || (rank_rd < hit_rank_q)) begin
      rank_wdata = rank_rd + IDX_W'(1);
    end else begin
      rank_wdata = rank_rd;
    end
  end

  lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (slot_sel),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (slot_sel),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (val_rd)
  );

  lkvc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (pend_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (raddr),
    .rdata_o (rank_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = null_ins ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_end) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = go_update ? ST_UPDATE : ST_RESP;
      end
      ST_UPDATE: begin
        if (cnt_end) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cap_d        = cfg_we_i ? cfg_wdata_i : cap_q;
    count_d      = count_q;
    valid_d      = valid_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    pend_idx_d   = raddr;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_rank_d   = hit_rank_q;
    hit_val_d    = hit_val_q;
    vict_idx_d   = vict_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d        = cmd_e'(command_i);
          key_d        = lookup_key_i;
          val_d        = entry_value_i;
          cnt_d        = '0;
          hit_d        = 1'b0;
          free_d       = 1'b0;
          res_status_d = null_ins ? STAT_NULL : STAT_OK;
          res_value_d  = '0;
        end
      end
      ST_SCAN: begin
        if (!cnt_end) begin
          cnt_d  = cnt_q + CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (pend_valid) begin
            if (!hit_q && (key_rd == key_q)) begin
              hit_d      = 1'b1;
              hit_idx_d  = pend_idx_q;
              hit_rank_d = rank_rd;
              hit_val_d  = val_rd;
            end
            if (CNT_W'(rank_rd) == (count_q - CNT_W'(1))) begin
              vict_idx_d = pend_idx_q;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = pend_idx_q;
          end
        end
      end
      ST_DECIDE: begin
        cnt_d = '0;
        if (cmd_q == CMD_INSERT) begin
          if (hit_q) begin
            res_status_d = STAT_DUP;
          end else if (go_update) begin
            if (over) begin
              valid_d[vict_idx_q] = 1'b0;
            end else begin
              count_d = count_q + CNT_W'(1);
            end
            valid_d[slot_sel] = 1'b1;
            slot_d            = slot_sel;
          end
        end else if (hit_q) begin
          slot_d      = hit_idx_q;
          res_value_d = hit_val_q;
        end else begin
          res_status_d = STAT_MISS;
        end
      end
      ST_UPDATE: begin
        if (!cnt_end) begin
          cnt_d  = cnt_q + CNT_W'(1);
          pend_d = 1'b1;
        end
      end
      ST_RESP: ;
      default: ;
    endcase

    if (state_q == ST_RESP && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_value_d  = res_value_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    val_q        <= val_d;
    pend_idx_q   <= pend_idx_d;
    hit_idx_q    <= hit_idx_d;
    hit_rank_q   <= hit_rank_d;
    hit_val_q    <= hit_val_d;
    vict_idx_q   <= vict_idx_d;
    free_idx_q   <= free_idx_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;

endmodule

// ===== rtl/lkvc_ram.sv =====
// ----------------------------------------------------------------------------
// lkvc_ram: generic single-write, single-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key/value cache
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_checker #(
  parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [VALUE_BITS-1:0] found_value_o
);

  import lkvc_pkg::*;

  // an accepted request keeps the input stalled while it is processed
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in flight");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(found_value_o))
    else $error("stalled result changed");

  // only a hit carries a value
  a_value_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (found_value_o != '0) |-> (status_o == STAT_OK))
    else $error("non-zero value with failing status");

  // no result appears in the cycle straight after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result produced without processing time");

endmodule

bind lru_key_value_cache_top lkvc_checker #(.VALUE_BITS(VALUE_BITS)) u_lkvc_checker (.*);

// ===== verif/tb_lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top: self-checking bench for the LRU key/value cache
// A shadow copy of the cache contents and recency order predicts the status
// and value of every request. Directed corner requests come first, then
// random phases across capacity settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int unsigned SLOTS       = ENTRIES_DEF;
  localparam int unsigned KW          = KEY_BITS_DEF;
  localparam int unsigned VW          = VALUE_BITS_DEF;
  localparam int unsigned POOL        = 24;
  localparam int unsigned QUIET_LIMIT = 5000;

  typedef struct packed {
    status_e       status;
    logic [VW-1:0] value;
  } lookup_result_t;

  class lru_mirror;
    logic [KW-1:0]  key_mem   [SLOTS];
    logic [VW-1:0]  value_mem [SLOTS];
    bit             live      [SLOTS];
    int unsigned    age       [SLOTS];
    int unsigned    n_live;
    int unsigned    capacity;
    lookup_result_t expected_q[$];
    int unsigned    mismatches, n_requests, n_hits, n_misses, n_dups, n_nulls, n_evictions;

    function new();
      n_live   = 0;
      capacity = CAP_RESET;
      foreach (live[i]) live[i] = 1'b0;
      mismatches = 0; n_requests = 0; n_hits = 0; n_misses = 0;
      n_dups = 0; n_nulls = 0; n_evictions = 0;
    endfunction

    function int locate(logic [KW-1:0] key);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && key_mem[i] == key) return i;
      return -1;
    endfunction

    function void note_request(cmd_e cmd, logic [KW-1:0] key, logic [VW-1:0] val);
      lookup_result_t res;
      int unsigned    lim;
      int             slot;
      bit             dropped;
      lim        = (capacity > SLOTS) ? SLOTS : capacity;
      res.status = STAT_OK;
      res.value  = '0;
      n_requests++;
      if (cmd == CMD_INSERT) begin
        if (val == '0) begin
          res.status = STAT_NULL;
          n_nulls++;
        end else if (locate(key) >= 0) begin
          res.status = STAT_DUP;
          n_dups++;
        end else if (n_live == 0 && lim == 0) begin
          n_evictions++;  // goes in and straight back out
        end else begin
          if (n_live + 1 > lim) begin
            dropped = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (!dropped && live[i] && age[i] == n_live - 1) begin
                live[i] = 1'b0;
                dropped = 1'b1;
              end
            end
            n_live--;
            n_evictions++;
          end
          slot = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i]) begin
              if (slot < 0) slot = i;
            end else begin
              age[i]++;
            end
          end
          if (slot >= 0) begin
            key_mem[slot]   = key;
            value_mem[slot] = val;
            age[slot]       = 0;
            live[slot]      = 1'b1;
            n_live++;
          end
        end
      end else begin
        slot = locate(key);
        if (slot < 0) begin
          res.status = STAT_MISS;
          n_misses++;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (live[i] && age[i] < age[slot]) age[i]++;
          age[slot] = 0;
          res.value = value_mem[slot];
          n_hits++;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_response(logic [1:0] status, logic [VW-1:0] found);
      lookup_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with no request outstanding: status %0d value 0x%h",
                 $time, status, found);
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
      end
      if (found !== want.value) begin
        mismatches++;
        $display("%0t: found_value expected 0x%h, actual 0x%h", $time, want.value, found);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CAP_BITS-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                command_i     = 1'b0;
  logic [KW-1:0]       lookup_key_i  = '0;
  logic [VW-1:0]       entry_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [1:0]          status_o;
  logic [VW-1:0]       found_value_o;

  lru_mirror   mirror;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_settings   = 0;

  lru_key_value_cache_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .lookup_key_i  (lookup_key_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.check_response(status_o, found_value_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(cmd_e cmd, logic [KW-1:0] key, logic [VW-1:0] val);
    int unsigned gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    lookup_key_i  <= key;
    entry_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(cmd, key, val);
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mirror.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_BITS-1:0] cap);
    drain_requests();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.capacity = cap;
    n_settings++;
  endtask

  initial begin
    int unsigned   caps      [8];
    int unsigned   idle_tab  [4];
    int unsigned   stall_tab [4];
    logic [KW-1:0] pool [POOL];
    logic [KW-1:0] key;
    logic [VW-1:0] val;
    cmd_e          cmd;
    int unsigned   lim, psize, pick;

    caps      = '{16, 2, 31, 0, 5, 1, 12, 17};
    idle_tab  = '{0, 50, 0, 22};
    stall_tab = '{0, 0, 50, 22};
    mirror = new();
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    pool[0] = '0;
    pool[1] = '1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero capacity on an empty cache: accepted then dropped
    set_capacity(CAP_BITS'(0));
    send_request(CMD_INSERT, pool[0], 32'd1);
    send_request(CMD_FIND,   pool[0], '1);
    send_request(CMD_INSERT, pool[1], '0);
    set_capacity(CAP_BITS'(1));
    send_request(CMD_INSERT, pool[0], '1);
    send_request(CMD_INSERT, pool[1], 32'd1);
    send_request(CMD_FIND,   pool[0], '0);
    send_request(CMD_FIND,   pool[1], '0);
    send_request(CMD_INSERT, pool[1], 32'd7);
    send_request(CMD_INSERT, pool[1], '0);  // null wins over duplicate
    set_capacity(CAP_BITS'(31));
    send_request(CMD_INSERT, pool[0], 32'h8000_0001);
    send_request(CMD_INSERT, pool[2], 32'h7fff_fffe);
    send_request(CMD_FIND,   pool[0], '1);
    send_request(CMD_FIND,   pool[3], '0);
    send_request(CMD_INSERT, pool[2], 32'h5);

    for (int p = 0; p < 8; p++) begin
      set_capacity(CAP_BITS'(caps[p]));
      idle_pct  = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      lim   = (caps[p] > SLOTS) ? SLOTS : caps[p];
      psize = lim + 6;
      for (int n = 0; n < 180; n++) begin
        if (n == 90) drain_requests();
        pick = $urandom_range(99);
        if (pick < 85) key = pool[$urandom_range(psize - 1)];
        else key = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 8) val = '0;
        else if (pick < 12) val = '1;
        else val = $urandom;
        cmd = $urandom_range(1) ? CMD_FIND : CMD_INSERT;
        send_request(cmd, key, val);
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain_requests();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests over %0d capacity settings and four idle/stall patterns.",
             mirror.n_requests, n_settings);
    $display("Hits %0d, misses %0d, duplicates %0d, null inserts %0d, evictions %0d.",
             mirror.n_hits, mirror.n_misses, mirror.n_dups, mirror.n_nulls,
             mirror.n_evictions);
    if (mirror.mismatches == 0 && mirror.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lru_key_value_cache_top.sv
rtl/lkvc_checker.sv
verif/tb_lru_key_value_cache_top.sv
